@@ design/lru_key_value_cache_macros.svh @@
// Assertion macros for the LRU key/value cache.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lru_key_value_cache: same-cycle check failed");
`define LKV_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lru_key_value_cache: next-cycle check failed");
`else
`define LKV_ASSERT_IMP(name, clk, rstn, ante, cons)
`define LKV_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

@@ design/lkv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache; no dependencies.
package lkv_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_KEY_BITS   = 32;

    localparam int ACTION_W      = 3;
    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 32;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_GOC    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [KEY_FIELD_W-1:0]   key;
        logic [VALUE_FIELD_W-1:0] value;
        logic                     value_present;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic                     created;
        logic [VALUE_FIELD_W-1:0] data;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming request
        logic lookup;  // compare keys, pick the target slot, read its data
        logic commit;  // apply the update and load the result register
    } cmd_t;

endpackage

@@ design/lkv_ctrl.sv @@
// Request sequencer of the LRU key/value cache: handshakes and phase control.
// Depends on lkv_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;
    logic   commit;

    // The result register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_UPDATE) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || commit;
    assign accept   = s_valid && s_ready;

    assign cmd.load   = accept;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = commit;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (commit) begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `LKV_ASSERT_NXT(a_lookup_then_update, aclk, aresetn, state_reg == ST_LOOKUP, state_reg == ST_UPDATE)
    `LKV_ASSERT_NXT(a_commit_shows_result, aclk, aresetn, commit, m_valid_reg)
    `LKV_ASSERT_NXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)

endmodule

@@ design/lkv_datapath.sv @@
// Slot storage, key compare, recency ranks and data memory of the LRU cache.
// Depends on lkv_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int KEY_BITS   = DEF_KEY_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    input  req_t s_req,
    output rsp_t m_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Request and per-slot state.
    req_t                  req_reg;
    logic [KEY_BITS-1:0]   key_reg  [ENTRIES];
    logic [IDX_W-1:0]      rank_reg [ENTRIES];
    logic [IDX_W-1:0]      rank_next[ENTRIES];
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [ENTRIES-1:0]    written_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] data_mem [ENTRIES];

    // Lookup results.
    logic                  hit_reg;
    logic                  full_reg;
    logic [ENTRIES-1:0]    tgt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      tgt_rank_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  rd_written_reg;

    rsp_t                  rsp_reg, rsp_next;

    logic [KEY_BITS-1:0]   key_m;
    logic [ENTRIES-1:0]    match, victim, free_vec, low_free, tgt;
    logic [IDX_W-1:0]      tgt_idx, tgt_rank;
    logic                  hit_c, full_c;

    assign key_m = req_reg.key[KEY_BITS-1:0];

    // Lookup phase: parallel compare, lowest free slot, least recent slot.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = valid_reg[i] && (key_reg[i] == key_m);
            victim[i] = valid_reg[i] && (rank_reg[i] == IDX_W'(ENTRIES - 1));
        end
        free_vec = ~valid_reg;
        low_free = free_vec & (~free_vec + ENTRIES'(1));
        hit_c    = |match;
        full_c   = &valid_reg;
        if (hit_c) begin
            tgt = match;
        end else if (full_c) begin
            tgt = victim;
        end else begin
            tgt = low_free;
        end
        tgt_idx  = '0;
        tgt_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tgt[i]) begin
                tgt_idx  = tgt_idx | IDX_W'(i);
                tgt_rank = tgt_rank | rank_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req;
        end
        if (cmd.lookup) begin
            hit_reg        <= hit_c;
            full_reg       <= full_c;
            tgt_reg        <= tgt;
            idx_reg        <= tgt_idx;
            tgt_rank_reg   <= tgt_rank;
            rd_data_reg    <= data_mem[tgt_idx];
            rd_written_reg <= written_reg[tgt_idx];
        end
    end

    // Update phase.
    logic                  is_get, is_set, is_goc, is_rem, is_clr;
    logic                  do_alloc, alloc_free, do_touch, do_remove, do_write;
    logic [VALUE_BITS-1:0] old_data, new_val, wr_data;

    always_comb begin
        is_get     = (req_reg.action == ACT_GET);
        is_set     = (req_reg.action == ACT_SET);
        is_goc     = (req_reg.action == ACT_GOC);
        is_rem     = (req_reg.action == ACT_REMOVE);
        is_clr     = (req_reg.action == ACT_CLEAR);
        do_alloc   = (is_set || is_goc) && !hit_reg;
        alloc_free = do_alloc && !full_reg;
        do_touch   = ((is_get || is_set || is_goc) && hit_reg) || do_alloc;
        do_remove  = is_rem && hit_reg;
        do_write   = is_set && (!hit_reg || req_reg.value_present);
        old_data   = rd_written_reg ? rd_data_reg : '0;
        new_val    = VALUE_BITS'(req_reg.value);
        wr_data    = req_reg.value_present ? new_val : '0;

        for (int i = 0; i < ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (is_clr) begin
                valid_next[i] = 1'b0;
                rank_next[i]  = '0;
            end else if (tgt_reg[i] && (do_touch || do_remove)) begin
                rank_next[i] = '0;
                if (do_remove) begin
                    valid_next[i] = 1'b0;
                end else if (alloc_free) begin
                    valid_next[i] = 1'b1;
                end
            end else if (do_touch && valid_reg[i]
                         && (alloc_free || rank_reg[i] < tgt_rank_reg)) begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end else if (do_remove && valid_reg[i] && rank_reg[i] > tgt_rank_reg) begin
                rank_next[i] = rank_reg[i] - IDX_W'(1);
            end
        end

        if (is_clr) begin
            count_next = '0;
        end else if (alloc_free) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end

        rsp_next.hit         = hit_reg && (is_get || is_set || is_goc || is_rem);
        rsp_next.created     = do_alloc;
        rsp_next.entry_count = COUNT_FIELD_W'(count_next);
        if (is_set) begin
            rsp_next.data = do_write ? VALUE_FIELD_W'(wr_data) : VALUE_FIELD_W'(old_data);
        end else if (is_goc || (is_get && hit_reg)) begin
            rsp_next.data = VALUE_FIELD_W'(old_data);
        end else begin
            rsp_next.data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            written_reg <= '0;
            count_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
            if (do_write) begin
                written_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
            if (do_alloc) begin
                key_reg[idx_reg] <= key_m;
            end
            if (do_write) begin
                data_mem[idx_reg] <= wr_data;
            end
        end
    end

    assign m_rsp = rsp_reg;

    `LKV_ASSERT_IMP(a_count_matches_valid, aclk, aresetn, 1'b1, $countones(valid_reg) == int'(count_reg))
    `LKV_ASSERT_IMP(a_keys_unique, aclk, aresetn, cmd.lookup, $onehot0(match))
    `LKV_ASSERT_NXT(a_target_onehot, aclk, aresetn, cmd.lookup, $onehot(tgt_reg))

endmodule

@@ design/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg, lkv_ctrl and lkv_datapath.
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready | req_t: action, key, value, value_present
//  m_       | out       | m_valid / m_ready | rsp_t: hit, created, data, entry_count
//
// Each request runs a lookup phase that compares the key against every slot in
// parallel and reads the target slot's data, then an update phase that rewrites
// the recency ranks, valid bits, count and data memory.
// A new request is accepted no earlier than the commit of the previous one, and
// the result is registered in the output register at that commit. The rank
// update of one request must finish before the next compare.
// Reset (aresetn low, synchronous) empties every slot and marks all data words
// as unwritten, so they read as zero; no clearing pass is needed.
// A result that waits on m_ready holds the update cycle; the next request is
// already taken while the previous result sits in the output register.

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int KEY_BITS   = DEF_KEY_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    // Command bundle from the sequencer into the datapath.
    cmd_t cmd;

    // The sequencer owns both handshakes and decides when each phase runs.
    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the slots, ranks, data memory and result register.
    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

endmodule
